FILE: sv/scp_pkg.sv
package scp_pkg;

    localparam int ORB_W = 64;
    localparam int TAG_W = 12;
    localparam int POS_W = 6;
    localparam int LVL_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [1:0] {
        KIND_DIAGONAL = 2'd0,
        KIND_SINGLE   = 2'd1,
        KIND_NONE     = 2'd2
    } t_kind;

    // one classified pair, as it sits in the result register
    typedef struct packed {
        logic [TAG_W-1:0] row_tag;
        logic [TAG_W-1:0] column_tag;
        t_kind            kind;
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] hole;
        logic [POS_W-1:0] particle;
        logic             sign_positive;
        logic [ORB_W-1:0] occupied_mask;
    } t_result;

endpackage

FILE: sv/scp_classify.sv
module scp_classify #(
    parameter int SPIN_ORBITALS = 64
) (
    input  logic [scp_pkg::TAG_W-1:0] i_first_index,
    input  logic [scp_pkg::TAG_W-1:0] i_second_index,
    input  logic [scp_pkg::ORB_W-1:0] i_first_occupation,
    input  logic [scp_pkg::ORB_W-1:0] i_second_occupation,
    output scp_pkg::t_result          o_result
);
    import scp_pkg::*;

    // only the low SPIN_ORBITALS bits take part
    localparam logic [ORB_W-1:0] KEEP = {ORB_W{1'b1}} >> (ORB_W - SPIN_ORBITALS);

    // adder tree over the 64 mask bits, six levels deep
    function automatic logic [CNT_W-1:0] f_popcount(input logic [ORB_W-1:0] v);
        logic [1:0] c2  [32];
        logic [2:0] c4  [16];
        logic [3:0] c8  [8];
        logic [4:0] c16 [4];
        logic [5:0] c32 [2];
        for (int k = 0; k < 32; k++) begin
            c2[k] = {1'b0, v[2*k]} + {1'b0, v[2*k+1]};
        end
        for (int k = 0; k < 16; k++) begin
            c4[k] = {1'b0, c2[2*k]} + {1'b0, c2[2*k+1]};
        end
        for (int k = 0; k < 8; k++) begin
            c8[k] = {1'b0, c4[2*k]} + {1'b0, c4[2*k+1]};
        end
        for (int k = 0; k < 4; k++) begin
            c16[k] = {1'b0, c8[2*k]} + {1'b0, c8[2*k+1]};
        end
        for (int k = 0; k < 2; k++) begin
            c32[k] = {1'b0, c16[2*k]} + {1'b0, c16[2*k+1]};
        end
        return {1'b0, c32[0]} + {1'b0, c32[1]};
    endfunction

    // highest set position, 0 when none
    function automatic logic [POS_W-1:0] f_top_bit(input logic [ORB_W-1:0] v);
        logic [POS_W-1:0] pos;
        pos = '0;
        for (int k = 0; k < ORB_W; k++) begin
            if (v[k]) begin
                pos = POS_W'(k);
            end
        end
        return pos;
    endfunction

    logic [ORB_W-1:0] occ_a;
    logic [ORB_W-1:0] occ_b;
    logic [CNT_W-1:0] diff_cnt;
    logic [LVL_W-1:0] level;
    logic [POS_W-1:0] hole;
    logic [POS_W-1:0] particle;
    logic [POS_W-1:0] pos_lo;
    logic [POS_W-1:0] pos_hi;
    logic [POS_W:0]   lo_plus;
    logic [ORB_W-1:0] between;
    logic             odd_between;

    assign occ_a    = i_first_occupation & KEEP;
    assign occ_b    = i_second_occupation & KEEP;
    assign diff_cnt = f_popcount(occ_a ^ occ_b);
    assign level    = diff_cnt[CNT_W-1:1];
    assign hole     = f_top_bit(occ_a & ~occ_b);
    assign particle = f_top_bit(~occ_a & occ_b);
    assign pos_lo   = (hole < particle) ? hole : particle;
    assign pos_hi   = (hole < particle) ? particle : hole;
    assign lo_plus  = {1'b0, pos_lo} + (POS_W+1)'(1);

    // bits strictly between lo and hi; empty when the two meet
    assign between     = ~({ORB_W{1'b1}} << pos_hi) & ({ORB_W{1'b1}} << lo_plus);
    assign odd_between = ^(occ_a & between);

    always_comb begin
        o_result               = '0;
        o_result.row_tag       = i_first_index;
        o_result.column_tag    = i_second_index;
        o_result.level         = level;
        o_result.kind          = KIND_NONE;
        if (level == '0) begin
            o_result.kind          = KIND_DIAGONAL;
            o_result.column_tag    = i_first_index;
            o_result.sign_positive = 1'b1;
            o_result.occupied_mask = occ_a;
        end else if (level == LVL_W'(1)) begin
            o_result.kind          = KIND_SINGLE;
            o_result.hole          = hole;
            o_result.particle      = particle;
            o_result.sign_positive = ~odd_between;
        end
    end

endmodule

FILE: sv/slater_condon_pair_classifier_unit.sv
// Slater-Condon pair classifier. Each input beat carries two determinant
// occupation masks (bit k = spin orbital k) and two index tags; each output
// beat gives the excitation level (differing bits halved), a kind (diagonal,
// single excitation, no interaction), for single excitations the highest
// hole and particle, the phase sign and, for diagonal pairs, the first
// mask. Bits at or above SPIN_ORBITALS are ignored. The block is a
// two-register pipe: an input register, one pass of bit logic (popcount,
// top-bit search, between-mask parity), and a result register. It takes
// one beat per cycle while o_in_stall is low. An accepted beat moves on
// to the result register once that register is free, and o_out_valid
// then shows it. A stalled output holds the result register, and the
// input register keeps filling until both are full; then o_in_stall rises.
module slater_condon_pair_classifier_unit #(
    parameter int SPIN_ORBITALS = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [scp_pkg::TAG_W-1:0] i_first_index,
    input  logic [scp_pkg::TAG_W-1:0] i_second_index,
    input  logic [scp_pkg::ORB_W-1:0] i_first_occupation,
    input  logic [scp_pkg::ORB_W-1:0] i_second_occupation,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [scp_pkg::TAG_W-1:0] o_row_tag,
    output logic [scp_pkg::TAG_W-1:0] o_column_tag,
    output logic [1:0]                o_kind,
    output logic [scp_pkg::LVL_W-1:0] o_excitation_level,
    output logic [scp_pkg::POS_W-1:0] o_hole,
    output logic [scp_pkg::POS_W-1:0] o_particle,
    output logic                      o_sign_positive,
    output logic [scp_pkg::ORB_W-1:0] o_occupied_mask
);
    import scp_pkg::*;

    // input register
    logic             r_in_vld;
    logic             n_in_vld;
    logic [TAG_W-1:0] r_idx_a;
    logic [TAG_W-1:0] r_idx_b;
    logic [ORB_W-1:0] r_occ_a;
    logic [ORB_W-1:0] r_occ_b;

    // result register
    logic             r_out_vld;
    logic             n_out_vld;
    t_result          r_res;
    t_result          n_res;

    logic             out_free;
    logic             load_out;
    logic             load_in;

    // the result register frees when empty or when its beat leaves
    assign out_free = !r_out_vld || !i_out_stall;
    assign load_out = r_in_vld && out_free;
    // the input register takes a beat when empty or when it moves on
    assign o_in_stall = r_in_vld && !out_free;
    assign load_in    = i_in_valid && !o_in_stall;

    assign n_in_vld  = load_in ? 1'b1 : (load_out ? 1'b0 : r_in_vld);
    assign n_out_vld = load_out ? 1'b1 : (out_free ? 1'b0 : r_out_vld);

    scp_classify #(
        .SPIN_ORBITALS(SPIN_ORBITALS)
    ) u_classify (
        .i_first_index      (r_idx_a),
        .i_second_index     (r_idx_b),
        .i_first_occupation (r_occ_a),
        .i_second_occupation(r_occ_b),
        .o_result           (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // payload: capture on load, hold otherwise
    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_idx_a <= i_first_index;
            r_idx_b <= i_second_index;
            r_occ_a <= i_first_occupation;
            r_occ_b <= i_second_occupation;
        end
        if (load_out) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_row_tag          = r_res.row_tag;
    assign o_column_tag       = r_res.column_tag;
    assign o_kind             = r_res.kind;
    assign o_excitation_level = r_res.level;
    assign o_hole             = r_res.hole;
    assign o_particle         = r_res.particle;
    assign o_sign_positive    = r_res.sign_positive;
    assign o_occupied_mask    = r_res.occupied_mask;

    // a waiting input beat must not be dropped while the output is stalled
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !out_free |=> r_in_vld)
        else $error("input beat lost under output stall");

    // a diagonal result repeats the row tag and has level zero
    a_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.kind == KIND_DIAGONAL |->
            r_res.column_tag == r_res.row_tag && r_res.level == '0)
        else $error("diagonal result malformed");

    // kind follows the level
    a_kind_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |->
            (r_res.kind == KIND_SINGLE) == (r_res.level == LVL_W'(1)) &&
            (r_res.kind == KIND_NONE) == (r_res.level > LVL_W'(1)))
        else $error("kind disagrees with excitation level");

    // only diagonal results carry the occupation mask
    a_mask_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_res.kind != KIND_DIAGONAL |-> r_res.occupied_mask == '0)
        else $error("mask on non-diagonal result");

    // a beat that leaves the input register is valid at the output next cycle
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> r_out_vld)
        else $error("result register failed to load");

endmodule

FILE: dv/tb_slater_condon_pair_classifier_unit.sv
module tb_slater_condon_pair_classifier_unit;

    import scp_pkg::*;

    localparam int ORBITALS       = 64;
    localparam int LONG_HOLD      = 60;   // receiver hold-off used to fill the pipe
    localparam int TAIL_CYCLES    = 10;   // the pipe is two registers deep; leave some slack
    localparam int WATCHDOG_LIMIT = 1000; // cycles with no beat on either side

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             o_in_stall;
    logic [TAG_W-1:0] first_index;
    logic [TAG_W-1:0] second_index;
    logic [ORB_W-1:0] first_occupation;
    logic [ORB_W-1:0] second_occupation;
    logic             o_out_valid;
    logic             out_stall;
    logic [TAG_W-1:0] o_row_tag;
    logic [TAG_W-1:0] o_column_tag;
    logic [1:0]       o_kind;
    logic [LVL_W-1:0] o_excitation_level;
    logic [POS_W-1:0] o_hole;
    logic [POS_W-1:0] o_particle;
    logic             o_sign_positive;
    logic [ORB_W-1:0] o_occupied_mask;

    // Classifications owed by the block, oldest first.
    t_result     pending_results[$];
    int unsigned mismatch_count;
    int unsigned quiet_cycles;

    // Idling knobs, flipped by the test sequence.
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_request;

    slater_condon_pair_classifier_unit #(
        .SPIN_ORBITALS(ORBITALS)
    ) uut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (o_in_stall),
        .i_first_index      (first_index),
        .i_second_index     (second_index),
        .i_first_occupation (first_occupation),
        .i_second_occupation(second_occupation),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (out_stall),
        .o_row_tag          (o_row_tag),
        .o_column_tag       (o_column_tag),
        .o_kind             (o_kind),
        .o_excitation_level (o_excitation_level),
        .o_hole             (o_hole),
        .o_particle         (o_particle),
        .o_sign_positive    (o_sign_positive),
        .o_occupied_mask    (o_occupied_mask)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Pair classifier prediction.
    // Cut both masks to the orbital count, count the differing bits and
    // halve them. Level 0 is diagonal, level 1 is a single excitation with
    // the highest hole and particle (0 when absent) and the phase sign from
    // the first-mask bits strictly between them, anything above is no
    // interaction.
    // ------------------------------------------------------------------
    function automatic t_result classify_pair(input logic [TAG_W-1:0] row,
                                              input logic [TAG_W-1:0] col,
                                              input logic [ORB_W-1:0] occ_a_in,
                                              input logic [ORB_W-1:0] occ_b_in);
        t_result          r;
        logic [ORB_W-1:0] keep;
        logic [ORB_W-1:0] occ_a;
        logic [ORB_W-1:0] occ_b;
        int unsigned      differing;
        int unsigned      hole_pos;
        int unsigned      particle_pos;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      between_count;
        r = '0;
        for (int k = 0; k < ORB_W; k++) begin
            keep[k] = (k < ORBITALS);
        end
        occ_a = occ_a_in & keep;
        occ_b = occ_b_in & keep;
        differing = $countones(occ_a ^ occ_b);
        r.row_tag    = row;
        r.column_tag = col;
        r.level      = LVL_W'(differing / 2);
        if (differing / 2 == 0) begin
            r.kind          = KIND_DIAGONAL;
            r.column_tag    = row;
            r.sign_positive = 1'b1;
            r.occupied_mask = occ_a;
        end else if (differing / 2 == 1) begin
            r.kind = KIND_SINGLE;
            hole_pos = 0;
            particle_pos = 0;
            for (int k = 0; k < ORB_W; k++) begin
                if (occ_a[k] && !occ_b[k]) hole_pos = k;
                if (!occ_a[k] && occ_b[k]) particle_pos = k;
            end
            lo = (hole_pos < particle_pos) ? hole_pos : particle_pos;
            hi = (hole_pos < particle_pos) ? particle_pos : hole_pos;
            between_count = 0;
            for (int k = 0; k < ORB_W; k++) begin
                if (k > lo && k < hi && occ_a[k]) between_count++;
            end
            r.hole          = POS_W'(hole_pos);
            r.particle      = POS_W'(particle_pos);
            r.sign_positive = ~between_count[0];
        end else begin
            r.kind = KIND_NONE;
        end
        return r;
    endfunction

    // Mix plain, sparse and dense occupations.
    function automatic logic [ORB_W-1:0] random_occupation();
        logic [ORB_W-1:0] m;
        m = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: m = m & {$urandom, $urandom};
            1: m = m | {$urandom, $urandom};
            default: ;
        endcase
        return m;
    endfunction

    // ------------------------------------------------------------------
    // Send one pair: optionally idle first, then present the beat and hold
    // it until accepted. Valid stays high on return so back-to-back beats
    // never drop it; anything that waits lowers it first.
    // ------------------------------------------------------------------
    task automatic send_pair(input logic [TAG_W-1:0] row,
                             input logic [TAG_W-1:0] col,
                             input logic [ORB_W-1:0] occ_a,
                             input logic [ORB_W-1:0] occ_b);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid          <= 1'b1;
        first_index       <= row;
        second_index      <= col;
        first_occupation  <= occ_a;
        second_occupation <= occ_b;
        @(posedge clk);
        while (o_in_stall) @(posedge clk);
        pending_results = {pending_results, classify_pair(row, col, occ_a, occ_b)};
    endtask

    // Drop valid and wait for every owed result.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic flag_field(input string field,
                              input logic [ORB_W-1:0] want,
                              input logic [ORB_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch on %0s: expected %0h, got %0h", field, want, got);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, all three kinds, missing hole or particle, odd and
    // even phase, edge orbitals.
    task automatic test_directed();
        send_pair(12'd0,    12'd0,    64'h0, 64'h0);
        send_pair(12'hFFF,  12'hFFF,  '1, '1);
        send_pair(12'h123,  12'hABC,  64'h1, 64'h0);                    // one bit differs
        send_pair(12'hFFF,  12'h000,  64'h8000_0000_0000_0000, 64'h0);
        send_pair(12'h001,  12'h002,  64'h5, 64'hC);                     // odd, hole below
        send_pair(12'h7FF,  12'h800,  64'h8000_0000_0010_0400,
                                      64'h0000_0000_0010_0401);          // even, hole above
        send_pair(12'h010,  12'h020,  64'h20, 64'h40);                   // adjacent
        send_pair(12'h030,  12'h040,  64'h88, 64'h0);                    // no particle
        send_pair(12'h050,  12'h060,  64'h0, 64'h4000_0000_0000_0002);   // no hole
        send_pair(12'h070,  12'h080,  64'h3, 64'h0);                     // hole 1, no particle
        send_pair(12'h090,  12'h0A0,  64'h0F, 64'hF0);                   // level 4
        send_pair(12'h0B0,  12'h0C0,  64'h0, '1);                        // level 32
        send_pair(12'h0D0,  12'h0E0,  64'h3, 64'h4);                     // three differ
        send_pair(12'h0F0,  12'h100,  64'h1F, 64'h0);                    // five differ
        send_pair(12'hAAA,  12'h555,  64'hAAAA_AAAA_AAAA_AAAA,
                                      64'h5555_5555_5555_5555);
        send_pair(12'hFFF,  12'h000,  64'hFFFF_FFFF_FFFF_FFFE,
                                      64'h7FFF_FFFF_FFFF_FFFF);          // 62 between
        send_pair(12'h000,  12'hFFF,  64'hFFFF_FFFF_FFFF_FFDE,
                                      64'h7FFF_FFFF_FFFF_FFDF);          // 61 between
        send_pair(12'h000,  12'hFFF,  64'h5555_5555_5555_5555,
                                      64'h5555_5555_5555_5555);
        send_pair(12'h321,  12'h654,  64'h0, 64'h7FFF_FFFF_FFFF_FFFF);   // level 31
        send_pair(12'h111,  12'h222,  64'h4000_0000_0000_0000,
                                      64'h8000_0000_0000_0000);
        drain_pipe();
    endtask

    // Hold the receiver off for a long stretch while beats keep coming, so
    // both pipe registers fill and the input stalls.
    task automatic test_output_backpressure();
        tx_idle_on   = 1'b0;
        hold_request = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_pair(12'($urandom), 12'($urandom), random_occupation(), random_occupation());
        end
        drain_pipe();
        tx_idle_on = 1'b1;
    endtask

    // Mostly near-diagonal pairs so single excitations dominate, with
    // diagonal, broken and fully random pairs mixed in.
    task automatic test_random_pairs(input int unsigned count);
        logic [ORB_W-1:0] occ_a;
        logic [ORB_W-1:0] occ_b;
        int unsigned      p;
        int unsigned      q;
        for (int unsigned n = 0; n < count; n++) begin
            occ_a = random_occupation();
            p = $urandom_range(0, ORB_W - 1);
            q = (p + $urandom_range(1, ORB_W - 1)) % ORB_W;
            case ($urandom_range(0, 9))
                0: occ_b = occ_a;
                1: begin
                    occ_b = occ_a;
                    occ_b[p] = ~occ_b[p];
                end
                2, 3, 4, 9: begin
                    // Move one electron; pin it to an edge orbital now and then.
                    if ($urandom_range(0, 9) == 9) begin
                        p = $urandom_range(0, 1) * (ORB_W - 1);
                        q = (p + $urandom_range(1, ORB_W - 1)) % ORB_W;
                    end
                    occ_a[p] = 1'b1;
                    occ_a[q] = 1'b0;
                    occ_b    = occ_a;
                    occ_b[p] = 1'b0;
                    occ_b[q] = 1'b1;
                end
                5: begin
                    occ_b = occ_a;
                    occ_b[p] = ~occ_b[p];
                    occ_b[q] = ~occ_b[q];
                end
                6: begin
                    occ_b = occ_a;
                    repeat ($urandom_range(3, 8)) begin
                        p = $urandom_range(0, ORB_W - 1);
                        occ_b[p] = ~occ_b[p];
                    end
                end
                7: occ_b = random_occupation();
                default: occ_b = ~occ_a;
            endcase
            send_pair(12'($urandom), 12'($urandom), occ_a, occ_b);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, or one long hold-off on request.
    // Each pass drives stall once and then waits on the clock before the next pass.
    // ------------------------------------------------------------------
    initial begin
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare every accepted result beat with the oldest
    // owed classification, field by field.
    // ------------------------------------------------------------------
    initial begin
        t_result want;
        forever begin
            @(posedge clk);
            if (rst_n && o_out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result beat with no pair outstanding: row %0h column %0h",
                                 o_row_tag, o_column_tag);
                end else begin
                    want = pending_results.pop_front();
                    if (o_row_tag !== want.row_tag)
                        flag_field("row_tag", want.row_tag, o_row_tag);
                    if (o_column_tag !== want.column_tag)
                        flag_field("column_tag", want.column_tag, o_column_tag);
                    if (o_kind !== want.kind)
                        flag_field("kind", want.kind, o_kind);
                    if (o_excitation_level !== want.level)
                        flag_field("excitation_level", want.level, o_excitation_level);
                    if (o_hole !== want.hole)
                        flag_field("hole", want.hole, o_hole);
                    if (o_particle !== want.particle)
                        flag_field("particle", want.particle, o_particle);
                    if (o_sign_positive !== want.sign_positive)
                        flag_field("sign_positive", want.sign_positive, o_sign_positive);
                    if (o_occupied_mask !== want.occupied_mask)
                        flag_field("occupied_mask", want.occupied_mask, o_occupied_mask);
                end
            end
        end
    end

    // Watchdog: end the run when no beat moves on either side for too long.
    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge clk);
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results owed", pending_results.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n             <= 1'b0;
        in_valid          <= 1'b0;
        first_index       <= '0;
        second_index      <= '0;
        first_occupation  <= '0;
        second_occupation <= '0;
        mismatch_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_directed();
        test_output_backpressure();
        test_random_pairs(450);
        // Pause the sender until every owed result is back.
        drain_pipe();

        // Final stretch runs flat out on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        test_random_pairs(350);

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
